>>> hw/rtl/c2p_pkg.sv
// Shared types, constants and tables for the Cartesian-to-polar converter.
package c2p_pkg;

  localparam int DATA_WIDTH_DEF  = 16;
  localparam int STAGE_COUNT_DEF = 16;

  // Fraction bits carried by x and y inside the rotation cells.
  localparam int GUARD_BITS = 8;
  // Extra integer bits for sign, the pi pre-rotation and CORDIC growth.
  localparam int GROWTH_BITS = 3;

  localparam int ANGLE_W = 16;
  localparam int PHASE_W = 32;

  // Gain compensation, unsigned Q22.
  localparam int GAIN_Q    = 22;
  localparam int GAIN_W    = 23;
  localparam int GAIN_BASE = 2547003;
  localparam int GAIN_TAIL = 1698002;

  localparam logic [PHASE_W-1:0] PHASE_PI   = 32'h8000_0000;
  localparam logic [PHASE_W-1:0] PHASE_HALF = 32'h0000_8000;

  localparam logic signed [ANGLE_W-1:0] ANGLE_ZERO        = 16'sh0000;
  localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI     = 16'sh4000;
  localparam logic signed [ANGLE_W-1:0] ANGLE_NEG_HALF_PI = 16'shC000;
  localparam logic signed [ANGLE_W-1:0] ANGLE_NEG_PI      = 16'sh8000;

  // atan(2^-i) in units of 2^32 per turn.
  localparam logic [PHASE_W-1:0] ATAN_UNITS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Axis handling, decided at the input and applied at the output.
  typedef enum logic [2:0] {
    SEL_NORMAL,
    SEL_POS_HALF,
    SEL_NEG_HALF,
    SEL_ZERO,
    SEL_NEG_PI
  } ang_sel_t;

  typedef struct packed {
    logic [PHASE_W-1:0] z;
    ang_sel_t           sel;
  } ang_t;

  function automatic logic [GAIN_W-1:0] c2p_gain_value(input int stage_count);
    int                sh;
    logic [GAIN_W-1:0] g;
    sh = 2 * stage_count;
    g  = GAIN_W'(GAIN_BASE);
    if (sh < 21) begin
      g = g + GAIN_W'(GAIN_TAIL >> sh);
    end
    return g;
  endfunction

endpackage

>>> hw/rtl/c2p_if.sv
// Valid/ready channel interfaces for the converter's input and result streams.
interface c2p_in_if #(
  parameter int DATA_WIDTH = c2p_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x_coord;
  logic signed [DATA_WIDTH-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_out_if #(
  parameter int DATA_WIDTH = c2p_pkg::DATA_WIDTH_DEF
);
  logic                                valid;
  logic                                ready;
  logic        [DATA_WIDTH-1:0]        magnitude;
  logic signed [c2p_pkg::ANGLE_W-1:0]  angle;

  modport source (output valid, output magnitude, output angle, input ready);
  modport sink   (input valid, input magnitude, input angle, output ready);
endinterface

>>> hw/rtl/cartesian_to_polar_converter.sv
// Top level: CORDIC vectoring converter from x,y to magnitude and binary angle.
// Pipeline: STAGE_COUNT + 3 register stages (entry, cells, gain, output); a result is
// taken at the next edge at the earliest. Every stage holds its own valid bit.
// Throughput: one transaction per clock while the output is not stalled.
// Stalls collapse bubbles: a stage fills whenever it is empty or its successor moves.
// Reset: synchronous rst_n clears only the stage valid bits; no clearing pass.
module cartesian_to_polar_converter #(
  parameter int DATA_WIDTH  = c2p_pkg::DATA_WIDTH_DEF,
  parameter int STAGE_COUNT = c2p_pkg::STAGE_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  c2p_in_if.sink    in_chan,
  c2p_out_if.source out_chan
);
  import c2p_pkg::*;

  // Internal coordinate width: data, guard fraction bits and growth headroom.
  localparam int XW   = DATA_WIDTH + GUARD_BITS + GROWTH_BITS;
  localparam int HALF = XW / 2;
  localparam int LW   = HALF + GAIN_W;
  localparam int HPW  = (XW - 1 - HALF) + GAIN_W;

  // Chain of stage boundaries: index 0 is the entry stage output,
  // index k+1 the output of rotation cell k.
  logic                 vld_s [STAGE_COUNT+1];
  logic                 rdy_s [STAGE_COUNT+1];
  logic signed [XW-1:0] x_s   [STAGE_COUNT+1];
  logic signed [XW-1:0] y_s   [STAGE_COUNT+1];
  ang_t                 ang_s [STAGE_COUNT+1];

  logic                 g_vld, g_rdy;
  logic [LW-1:0]        g_lo;
  logic [HPW-1:0]       g_hi;
  ang_t                 g_ang;

  // Entry: scale by the guard bits, rotate left half-plane by pi,
  // and classify the axis cases that override the computed angle.
  c2p_entry #(
    .DATA_WIDTH(DATA_WIDTH),
    .XW        (XW)
  ) u_entry (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(in_chan.valid),
    .up_ready(in_chan.ready),
    .x_coord (in_chan.x_coord),
    .y_coord (in_chan.y_coord),
    .dn_valid(vld_s[0]),
    .dn_ready(rdy_s[0]),
    .x_out   (x_s[0]),
    .y_out   (y_s[0]),
    .ang_out (ang_s[0])
  );

  // Rotation cells: cell k drives y toward zero with shift k and atan(2^-k).
  for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_cell
    c2p_cell #(
      .XW (XW),
      .IDX(k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_valid(vld_s[k]),
      .up_ready(rdy_s[k]),
      .x_in    (x_s[k]),
      .y_in    (y_s[k]),
      .ang_in  (ang_s[k]),
      .dn_valid(vld_s[k+1]),
      .dn_ready(rdy_s[k+1]),
      .x_out   (x_s[k+1]),
      .y_out   (y_s[k+1]),
      .ang_out (ang_s[k+1])
    );
  end

  // Gain compensation: two partial products of the final x, registered.
  // y of the last cell is the residual and is not used further.
  c2p_gain #(
    .XW         (XW),
    .STAGE_COUNT(STAGE_COUNT)
  ) u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(vld_s[STAGE_COUNT]),
    .up_ready(rdy_s[STAGE_COUNT]),
    .x_in    (x_s[STAGE_COUNT]),
    .ang_in  (ang_s[STAGE_COUNT]),
    .dn_valid(g_vld),
    .dn_ready(g_rdy),
    .lo_out  (g_lo),
    .hi_out  (g_hi),
    .ang_out (g_ang)
  );

  // Output register: rounded, saturated magnitude and the final angle.
  c2p_out #(
    .DATA_WIDTH(DATA_WIDTH),
    .XW        (XW)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (g_vld),
    .up_ready (g_rdy),
    .lo_in    (g_lo),
    .hi_in    (g_hi),
    .ang_in   (g_ang),
    .dn_valid (out_chan.valid),
    .dn_ready (out_chan.ready),
    .magnitude(out_chan.magnitude),
    .angle    (out_chan.angle)
  );

endmodule

>>> hw/rtl/c2p_entry.sv
// Input stage: scaling, pi pre-rotation for negative x and axis classification.
module c2p_entry #(
  parameter int DATA_WIDTH = 16,
  parameter int XW         = 27
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [DATA_WIDTH-1:0] x_coord,
  input  logic signed [DATA_WIDTH-1:0] y_coord,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [XW-1:0]         x_out,
  output logic signed [XW-1:0]         y_out,
  output c2p_pkg::ang_t                ang_out
);
  import c2p_pkg::*;

  logic                 v_r, v_nxt;
  logic                 load;
  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [XW-1:0] xe, ye;
  ang_t                 a_r, a_nxt;
  logic                 x_neg, x_zero, y_zero;

  assign up_ready = !v_r || dn_ready;
  assign load     = up_valid && up_ready;

  assign x_neg  = x_coord[DATA_WIDTH-1];
  assign x_zero = (x_coord == '0);
  assign y_zero = (y_coord == '0);

  assign xe = {{(XW-DATA_WIDTH){x_coord[DATA_WIDTH-1]}}, x_coord} <<< GUARD_BITS;
  assign ye = {{(XW-DATA_WIDTH){y_coord[DATA_WIDTH-1]}}, y_coord} <<< GUARD_BITS;

  always_comb begin
    if (x_neg) begin
      x_nxt   = -xe;
      y_nxt   = -ye;
      a_nxt.z = PHASE_PI;
    end else begin
      x_nxt   = xe;
      y_nxt   = ye;
      a_nxt.z = '0;
    end
    // y on the axis wins over x on the axis
    priority if (y_zero) begin
      a_nxt.sel = (!x_neg && !x_zero) ? SEL_ZERO : SEL_NEG_PI;
    end else if (x_zero) begin
      a_nxt.sel = y_coord[DATA_WIDTH-1] ? SEL_NEG_HALF : SEL_POS_HALF;
    end else begin
      a_nxt.sel = SEL_NORMAL;
    end
    v_nxt = load ? 1'b1 : (dn_ready ? 1'b0 : v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      a_r <= a_nxt;
    end
  end

  assign dn_valid = v_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign ang_out  = a_r;

endmodule

>>> hw/rtl/c2p_cell.sv
// One CORDIC vectoring iteration with its own stage register and handshake.
module c2p_cell #(
  parameter int XW  = 27,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  c2p_pkg::ang_t        ang_in,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output c2p_pkg::ang_t        ang_out
);
  import c2p_pkg::*;

  localparam logic [PHASE_W-1:0] ANG_STEP = ATAN_UNITS[IDX];

  logic                 v_r, v_nxt;
  logic                 load;
  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [XW-1:0] dx, dy;
  ang_t                 a_r, a_nxt;

  assign up_ready = !v_r || dn_ready;
  assign load     = up_valid && up_ready;

  // arithmetic shifts: floor toward minus infinity
  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;

  always_comb begin
    a_nxt.sel = ang_in.sel;
    if (y_in[XW-1]) begin
      x_nxt   = x_in - dx;
      y_nxt   = y_in + dy;
      a_nxt.z = ang_in.z - ANG_STEP;
    end else begin
      x_nxt   = x_in + dx;
      y_nxt   = y_in - dy;
      a_nxt.z = ang_in.z + ANG_STEP;
    end
    v_nxt = load ? 1'b1 : (dn_ready ? 1'b0 : v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      a_r <= a_nxt;
    end
  end

  assign dn_valid = v_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign ang_out  = a_r;

endmodule

>>> hw/rtl/c2p_gain.sv
// Gain compensation multiply, split into two half-width partial products.
module c2p_gain #(
  parameter int XW          = 27,
  parameter int STAGE_COUNT = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    up_valid,
  output logic                                    up_ready,
  input  logic signed [XW-1:0]                    x_in,
  input  c2p_pkg::ang_t                           ang_in,
  output logic                                    dn_valid,
  input  logic                                    dn_ready,
  output logic [(XW/2)+c2p_pkg::GAIN_W-1:0]       lo_out,
  output logic [(XW-1-XW/2)+c2p_pkg::GAIN_W-1:0]  hi_out,
  output c2p_pkg::ang_t                           ang_out
);
  import c2p_pkg::*;

  localparam int UW   = XW - 1;
  localparam int HALF = XW / 2;
  localparam int HW   = UW - HALF;
  localparam int LW   = HALF + GAIN_W;
  localparam int HPW  = HW + GAIN_W;
  localparam logic [GAIN_W-1:0] GAIN = c2p_gain_value(STAGE_COUNT);

  logic          v_r, v_nxt;
  logic          load;
  logic [UW-1:0] xu;
  logic [LW-1:0] lo_r, lo_nxt;
  logic [HPW-1:0] hi_r, hi_nxt;
  ang_t          a_r;

  assign up_ready = !v_r || dn_ready;
  assign load     = up_valid && up_ready;

  // negative length is clamped to zero
  assign xu = x_in[XW-1] ? '0 : x_in[UW-1:0];

  always_comb begin
    lo_nxt = LW'(xu[HALF-1:0]) * LW'(GAIN);
    hi_nxt = HPW'(xu[UW-1:HALF]) * HPW'(GAIN);
    v_nxt  = load ? 1'b1 : (dn_ready ? 1'b0 : v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      a_r  <= ang_in;
    end
  end

  assign dn_valid = v_r;
  assign lo_out   = lo_r;
  assign hi_out   = hi_r;
  assign ang_out  = a_r;

endmodule

>>> hw/rtl/c2p_out.sv
// Output stage: partial product sum, rounding, saturation and angle select.
module c2p_out #(
  parameter int DATA_WIDTH = 16,
  parameter int XW         = 27
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    up_valid,
  output logic                                    up_ready,
  input  logic [(XW/2)+c2p_pkg::GAIN_W-1:0]       lo_in,
  input  logic [(XW-1-XW/2)+c2p_pkg::GAIN_W-1:0]  hi_in,
  input  c2p_pkg::ang_t                           ang_in,
  output logic                                    dn_valid,
  input  logic                                    dn_ready,
  output logic [DATA_WIDTH-1:0]                   magnitude,
  output logic signed [c2p_pkg::ANGLE_W-1:0]      angle
);
  import c2p_pkg::*;

  localparam int HALF = XW / 2;
  localparam int PW   = XW - 1 + GAIN_W;
  localparam int SH   = GUARD_BITS + GAIN_Q;
  localparam int QW   = PW - SH;
  localparam logic [PW-1:0] RND = PW'(1) << (SH - 1);

  logic                        v_r, v_nxt;
  logic                        load;
  logic [PW-1:0]               prod;
  logic [QW-1:0]               q;
  logic [DATA_WIDTH-1:0]       mag_r, mag_nxt;
  logic [PHASE_W-1:0]          zr;
  logic signed [ANGLE_W-1:0]   ang_r, ang_nxt;

  assign up_ready = !v_r || dn_ready;
  assign load     = up_valid && up_ready;

  assign prod = (PW'(hi_in) << HALF) + PW'(lo_in) + RND;
  assign q    = prod[PW-1:SH];
  assign zr   = ang_in.z + PHASE_HALF;

  always_comb begin
    mag_nxt = (|q[QW-1:DATA_WIDTH]) ? '1 : q[DATA_WIDTH-1:0];
    unique case (ang_in.sel)
      SEL_NORMAL:   ang_nxt = zr[PHASE_W-1:PHASE_W-ANGLE_W];
      SEL_POS_HALF: ang_nxt = ANGLE_HALF_PI;
      SEL_NEG_HALF: ang_nxt = ANGLE_NEG_HALF_PI;
      SEL_ZERO:     ang_nxt = ANGLE_ZERO;
      SEL_NEG_PI:   ang_nxt = ANGLE_NEG_PI;
      default:      ang_nxt = zr[PHASE_W-1:PHASE_W-ANGLE_W];
    endcase
    v_nxt = load ? 1'b1 : (dn_ready ? 1'b0 : v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag_r <= mag_nxt;
      ang_r <= ang_nxt;
    end
  end

  assign dn_valid  = v_r;
  assign magnitude = mag_r;
  assign angle     = ang_r;

endmodule

>>> hw/rtl/c2p_checker.sv
// Port-level checker for the converter, bound to the top level.
module c2p_checker #(
  parameter int DATA_WIDTH  = c2p_pkg::DATA_WIDTH_DEF,
  parameter int STAGE_COUNT = c2p_pkg::STAGE_COUNT_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [DATA_WIDTH-1:0]               out_magnitude,
  input logic signed [c2p_pkg::ANGLE_W-1:0]  out_angle
);
  import c2p_pkg::*;

  localparam int DEPTH = STAGE_COUNT + 3;
  localparam int CW    = $clog2(DEPTH + 2) + 1;

  logic          in_acc, out_acc;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions inside the pipeline
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_magnitude) && $stable(out_angle))
    else $error("result changed or dropped while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result without a pending input transaction");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("more transactions in flight than pipeline stages");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled while the output stage can move");

endmodule

bind cartesian_to_polar_converter c2p_checker #(
  .DATA_WIDTH (DATA_WIDTH),
  .STAGE_COUNT(STAGE_COUNT)
) u_c2p_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_magnitude(out_chan.magnitude),
  .out_angle    (out_chan.angle)
);

>>> tb/cartesian_to_polar_converter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the CORDIC x,y to magnitude/angle converter.
module cartesian_to_polar_converter_tb;
  import c2p_pkg::*;

  localparam int W           = DATA_WIDTH_DEF;
  localparam int STAGES      = STAGE_COUNT_DEF;
  localparam int RANDOM_CNT  = 1930;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_WAIT  = 40;    // pipeline is STAGES + 3 deep, plus margin
  localparam int MAX_WAIT    = 18;

  // Four-quadrant atan2 in 2^32 units per turn; half a turn preset for x < 0.
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  // With 16 stages the gain tail term shifts out entirely, leaving the base.
  localparam longint MAG_GAIN = 2547003;
  // Magnitude drops guard bits plus the Q22 gain fraction, rounded.
  localparam int MAG_SHIFT = GUARD_BITS + GAIN_Q;

  // round(atan(2^-i) * 2^31 / pi) for the stages in use.
  localparam logic [31:0] ARCTAN_STEP [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct packed {
    logic        [W-1:0]       magnitude;
    logic signed [ANGLE_W-1:0] angle;
  } polar_t;

  // Directed row: fixed fields are typed in, the rest come from the predictor.
  typedef struct packed {
    logic signed [W-1:0]       x;
    logic signed [W-1:0]       y;
    logic                      fix_mag;
    logic        [W-1:0]       mag;
    logic                      fix_ang;
    logic signed [ANGLE_W-1:0] ang;
  } pair_row_t;

  localparam int N_ROWS = 23;
  localparam pair_row_t AXIS_ROWS [N_ROWS] = '{
    // origin: zero length, angle falls to -pi
    '{16'sd0,      16'sd0,      1'b1, 16'd0, 1'b1, ANGLE_NEG_PI},
    // on the y axis: +-pi/2 by sign of y
    '{16'sd0,      16'sd1,      1'b0, 16'd0, 1'b1, ANGLE_HALF_PI},
    '{16'sd0,      16'sd32767,  1'b0, 16'd0, 1'b1, ANGLE_HALF_PI},
    '{16'sd0,      -16'sd1,     1'b0, 16'd0, 1'b1, ANGLE_NEG_HALF_PI},
    '{16'sd0,      -16'sd32768, 1'b0, 16'd0, 1'b1, ANGLE_NEG_HALF_PI},
    // on the x axis: 0 for x > 0, -pi for x < 0
    '{16'sd1,      16'sd0,      1'b0, 16'd0, 1'b1, ANGLE_ZERO},
    '{16'sd32767,  16'sd0,      1'b0, 16'd0, 1'b1, ANGLE_ZERO},
    '{-16'sd1,     16'sd0,      1'b0, 16'd0, 1'b1, ANGLE_NEG_PI},
    '{-16'sd32768, 16'sd0,      1'b0, 16'd0, 1'b1, ANGLE_NEG_PI},
    // corners: largest magnitudes
    '{16'sd32767,  16'sd32767,  1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    '{-16'sd32768, -16'sd32768, 1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    '{-16'sd32768, 16'sd32767,  1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    '{16'sd32767,  -16'sd32768, 1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    // unit diagonals in all four quadrants
    '{16'sd1,      16'sd1,      1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    '{-16'sd1,     16'sd1,      1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    '{-16'sd1,     -16'sd1,     1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    '{16'sd1,      -16'sd1,     1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    // just off the negative x axis: angle lands on the +pi/-pi seam
    '{-16'sd32768, 16'sd1,      1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    '{-16'sd32768, -16'sd1,     1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    '{-16'sd2,     16'sd1,      1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    // alternating bit patterns and arbitrary points
    '{16'sd21845,  -16'sd21846, 1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    '{16'sd30000,  -16'sd17321, 1'b0, 16'd0, 1'b0, ANGLE_ZERO},
    '{-16'sd5,     16'sd12345,  1'b0, 16'd0, 1'b0, ANGLE_ZERO}
  };

  logic clk = 1'b0;
  logic rst_n;

  c2p_in_if  #(.DATA_WIDTH(W)) in_if ();
  c2p_out_if #(.DATA_WIDTH(W)) out_if ();

  cartesian_to_polar_converter #(
    .DATA_WIDTH (W),
    .STAGE_COUNT(STAGES)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  polar_t pending_polar [$];
  int     mismatch_count = 0;
  int     results_seen   = 0;
  int     pairs_sent     = 0;
  int     axis_pairs     = 0;
  int     idle_cycles    = 0;
  bit     send_busy      = 1'b1;  // sender draws gaps when set, else back-to-back
  bit     recv_busy      = 1'b1;  // receiver draws stalls when set

  // Bit-exact CORDIC vectoring: pre-rotate by pi for x < 0, then drive y to 0.
  function automatic polar_t polar_of(input logic signed [W-1:0] xc,
                                      input logic signed [W-1:0] yc);
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    longint      prod;
    logic [31:0] z;
    logic [31:0] z_rnd;
    polar_t      r;
    x = longint'(xc) * (longint'(1) << GUARD_BITS);
    y = longint'(yc) * (longint'(1) << GUARD_BITS);
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;  // arithmetic shift == floor
      dy = x >>> i;
      if (y < 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_STEP[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_STEP[i];
      end
    end
    if (x < 0) x = 0;
    prod = x * MAG_GAIN;
    prod = (prod + (longint'(1) << (MAG_SHIFT - 1))) >>> MAG_SHIFT;
    if (prod > longint'((1 << W) - 1)) prod = (1 << W) - 1;
    r.magnitude = prod[W-1:0];
    z_rnd   = z + 32'h0000_8000;
    r.angle = z_rnd[31:16];
    // axis overrides; y == 0 wins over x == 0
    if (xc == 0) r.angle = (yc > 0) ? ANGLE_HALF_PI : ANGLE_NEG_HALF_PI;
    if (yc == 0) r.angle = (xc > 0) ? ANGLE_ZERO : ANGLE_NEG_PI;
    return r;
  endfunction

  function automatic int draw_wait(input bit busy);
    return busy ? int'($urandom_range(0, MAX_WAIT)) : 0;
  endfunction

  // One input transaction: optional gap, then hold valid until taken.
  // Called right after a rising edge; valid moves at most once per edge.
  task automatic send_pair(input logic signed [W-1:0] x, input logic signed [W-1:0] y,
                           input polar_t want);
    int gap;
    gap = draw_wait(send_busy);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.x_coord <= x;
    in_if.y_coord <= y;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    pending_polar.push_back(want);
    pairs_sent++;
    if (x == 0 || y == 0) axis_pairs++;
  endtask

  // Sender pause: hold off until every outstanding result has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_polar.size() != 0) @(posedge clk);
  endtask

  // Random pair: mostly full range, with weight on small values, the axes,
  // the pi seam, diagonals and the extreme codes.
  task automatic random_pair(output logic signed [W-1:0] x, output logic signed [W-1:0] y);
    int kind;
    logic signed [W-1:0] ext [5];
    ext  = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    kind = $urandom_range(0, 99);
    x = W'($urandom);
    y = W'($urandom);
    if (kind < 55) begin
      // full range as drawn
    end else if (kind < 70) begin
      x = W'($urandom_range(0, 128)) - W'(64);
      y = W'($urandom_range(0, 128)) - W'(64);
    end else if (kind < 82) begin
      if ($urandom_range(0, 1)) x = '0;
      else y = '0;
    end else if (kind < 90) begin
      // near the negative x axis
      x = -W'($urandom_range(1, 32768));
      y = W'($urandom_range(0, 8)) - W'(4);
    end else if (kind < 95) begin
      y = $urandom_range(0, 1) ? x : -x;
    end else begin
      x = ext[$urandom_range(0, 4)];
      y = ext[$urandom_range(0, 4)];
    end
  endtask

  // Result side: when busy, stall a random number of cycles, then take one transaction.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_busy = !recv_busy;
      stall = draw_wait(recv_busy);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // Result checker: each accepted transaction against the oldest expectation.
  always @(posedge clk) begin
    polar_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_polar.size() == 0) begin
        $display("%t: unexpected result magnitude %0d angle %0d", $realtime,
                 out_if.magnitude, out_if.angle);
        mismatch_count++;
      end else begin
        want = pending_polar.pop_front();
        if (out_if.magnitude !== want.magnitude) begin
          $display("%t: magnitude mismatch: expected %0d actual %0d", $realtime,
                   want.magnitude, out_if.magnitude);
          mismatch_count++;
        end
        if (out_if.angle !== want.angle) begin
          $display("%t: angle mismatch: expected %0d actual %0d", $realtime,
                   want.angle, out_if.angle);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Stimulus: directed table, pause, random pairs in gap/burst phases, drain.
  initial begin
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    polar_t              want;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.x_coord <= '0;
    in_if.y_coord <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      want = polar_of(AXIS_ROWS[r].x, AXIS_ROWS[r].y);
      if (AXIS_ROWS[r].fix_mag) want.magnitude = AXIS_ROWS[r].mag;
      if (AXIS_ROWS[r].fix_ang) want.angle = AXIS_ROWS[r].ang;
      send_pair(AXIS_ROWS[r].x, AXIS_ROWS[r].y, want);
    end
    wait_drained();

    for (int n = 0; n < RANDOM_CNT; n++) begin
      // new idle phase every 100 pairs; about a third run back-to-back
      if (n % 100 == 0) send_busy = ($urandom_range(0, 2) != 0);
      if (n == RANDOM_CNT / 2) wait_drained();
      random_pair(x, y);
      send_pair(x, y, polar_of(x, y));
    end
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("summary: %0d pairs sent (%0d directed, %0d on an axis), %0d results checked",
             pairs_sent, N_ROWS, axis_pairs, results_seen);
    $display("summary: %0d mismatches, %0d results still outstanding",
             mismatch_count, pending_polar.size());
    if (mismatch_count == 0 && pending_polar.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/c2p_pkg.sv
hw/rtl/c2p_if.sv
hw/rtl/c2p_entry.sv
hw/rtl/c2p_cell.sv
hw/rtl/c2p_gain.sv
hw/rtl/c2p_out.sv
hw/rtl/cartesian_to_polar_converter.sv
hw/rtl/c2p_checker.sv
tb/cartesian_to_polar_converter_tb.sv
